### src/qtls_pkg.sv
// Shared types and constants for the quad-tree level and cell selector.
// No dependencies; every other file of the block imports this package.
package qtls_pkg;

    localparam int CORNER_W = 32;
    localparam int REG_W    = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int LEVEL_W  = 3;
    localparam int CELL_W   = 7;
    localparam int NODE_W   = 15;

    localparam logic [REG_W-1:0] HALF_EXTENT_RESET = 31'd65536;
    localparam logic [REG_W-1:0] GRID_SCALE_RESET  = 31'd8355840;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_EXTENT = 2'd0,
        REG_GRID_SCALE  = 2'd1
    } t_reg_index;

    typedef struct packed {
        logic signed [CORNER_W-1:0] box_min_x;
        logic signed [CORNER_W-1:0] box_min_y;
        logic signed [CORNER_W-1:0] box_max_x;
        logic signed [CORNER_W-1:0] box_max_y;
    } t_box;

    typedef struct packed {
        logic                outside_area;
        logic [LEVEL_W-1:0]  tree_level;
        logic [CELL_W-1:0]   cell_x;
        logic [CELL_W-1:0]   cell_y;
        logic [NODE_W-1:0]   node_index;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] wr_data;
    } t_cfg;

endpackage

### src/qtls_if.sv
// Handshake channels of the quad-tree level and cell selector: box, result, configuration.
// Depends on qtls_pkg for the payload types.
interface qtls_box_if;
    import qtls_pkg::*;
    logic valid;
    logic ready;
    t_box data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qtls_res_if;
    import qtls_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qtls_cfg_if;
    import qtls_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/quadtree_level_and_cell_select_unit.sv
// Top level of the quad-tree level and cell selector: a five-stage pipeline.
// Depends on qtls_pkg and the channel interfaces in qtls_if.sv.
//
//  Port     Direction  Word carried
//  i_box    in         one bounding box, four signed Q corners
//  o_res    out        outside flag, level, cell column and row, node index
//  i_cfg    in         register index and write data (always ready)
//
// One box is taken every cycle unless a stalled result backs up into the first stage; each result
// is registered after each stage in turn: the shift and area check, the corner multiply, rounding and
// clamp, the level search and the cell and index arithmetic.
// Reset clears the stage valid bits and loads the register reset values.
// A stage moves on whenever the stage after it is empty or moving, so bubbles close up
// and a stalled result holds only the stages that are full behind it.
module quadtree_level_and_cell_select_unit #(
    parameter int LEVEL_COUNT   = 8,
    parameter int FRACTION_BITS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    qtls_box_if.sink    i_box,
    qtls_res_if.source  o_res,
    qtls_cfg_if.sink    i_cfg
);
    import qtls_pkg::*;

    localparam int LW      = $clog2(LEVEL_COUNT);
    localparam int SW      = CORNER_W + 1;
    localparam int PROD_W  = CORNER_W + REG_W;
    localparam int QW      = PROD_W - 2 * FRACTION_BITS;
    localparam int NW      = 2 * LEVEL_COUNT + 16;
    localparam logic [QW:0] GRID_MAX = (QW + 1)'((1 << LEVEL_COUNT) - 1);
    localparam logic [NW-1:0] ALT_ONES = {(NW / 2){2'b01}};

    // Configuration registers
    logic [REG_W-1:0] r_half_extent;
    logic [REG_W-1:0] r_grid_scale;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_extent <= HALF_EXTENT_RESET;
            r_grid_scale  <= GRID_SCALE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_HALF_EXTENT: r_half_extent <= i_cfg.data.wr_data[REG_W-1:0];
                REG_GRID_SCALE:  r_grid_scale  <= i_cfg.data.wr_data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || o_res.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_box.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_box.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 1: shift corners into the area and check the area bounds.
    // Corners are numbered min x, min y, max x, max y.
    logic signed [CORNER_W-1:0] corner [4];
    logic [SW-1:0]       shifted [4];
    logic [SW-1:0]       over_x, over_y;
    logic [CORNER_W-1:0] n_s1_mag [4];
    logic [3:0]          n_s1_pos;
    logic                n_s1_out;
    logic [CORNER_W-1:0] r_s1_mag [4];
    logic [3:0]          r_s1_pos;
    logic                r_s1_out;

    always_comb begin
        corner[0] = i_box.data.box_min_x;
        corner[1] = i_box.data.box_min_y;
        corner[2] = i_box.data.box_max_x;
        corner[3] = i_box.data.box_max_y;
        for (int c = 0; c < 4; c++) begin
            shifted[c]  = {corner[c][CORNER_W-1], corner[c]} + {2'b00, r_half_extent};
            n_s1_mag[c] = shifted[c][CORNER_W-1:0];
            n_s1_pos[c] = !shifted[c][SW-1] && (shifted[c] != '0);
        end
        // A maximum is over the area when max - half_extent is strictly positive.
        over_x = {corner[2][CORNER_W-1], corner[2]} - {2'b00, r_half_extent};
        over_y = {corner[3][CORNER_W-1], corner[3]} - {2'b00, r_half_extent};
        n_s1_out = shifted[0][SW-1] || shifted[1][SW-1]
                || (!over_x[SW-1] && (over_x != '0))
                || (!over_y[SW-1] && (over_y != '0));
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mag <= n_s1_mag;
            r_s1_pos <= n_s1_pos;
            r_s1_out <= n_s1_out;
        end
    end

    // Stage 2: scale each shifted corner onto the grid.
    logic [PROD_W-1:0] r_s2_prod [4];
    logic [3:0]        r_s2_pos;
    logic              r_s2_out;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int c = 0; c < 4; c++) begin
                r_s2_prod[c] <= PROD_W'(r_s1_mag[c]) * PROD_W'(r_grid_scale);
            end
            r_s2_pos <= r_s1_pos;
            r_s2_out <= r_s1_out;
        end
    end

    // Stage 3: floor the minimums, ceil the maximums, clamp to the grid.
    logic [QW:0]             rounded [4];
    logic [LEVEL_COUNT-1:0]  n_s3_grid [4];
    logic [LEVEL_COUNT-1:0]  r_s3_grid [4];
    logic                    r_s3_out;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rounded[c] = {1'b0, r_s2_prod[c][PROD_W-1:2*FRACTION_BITS]}
                       + (QW + 1)'((c >= 2) && (r_s2_prod[c][2*FRACTION_BITS-1:0] != '0));
            if (!r_s2_pos[c]) begin
                n_s3_grid[c] = '0;
            end else if (rounded[c] > GRID_MAX) begin
                n_s3_grid[c] = GRID_MAX[LEVEL_COUNT-1:0];
            end else begin
                n_s3_grid[c] = rounded[c][LEVEL_COUNT-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_grid <= n_s3_grid;
            r_s3_out  <= r_s2_out;
        end
    end

    // Stage 4: the level on each axis follows the highest bit where min and max differ.
    // A zero difference finds no bit and lands on the finest level, as does bit zero.
    logic [LEVEL_COUNT-1:0] diff_x, diff_y;
    logic [LW-1:0]          top_x, top_y, lvl_x, lvl_y;
    logic [LW-1:0]          r_s4_lvl;
    logic [LEVEL_COUNT-1:0] r_s4_gx, r_s4_gy;
    logic                   r_s4_out;

    always_comb begin
        diff_x = r_s3_grid[0] ^ r_s3_grid[2];
        diff_y = r_s3_grid[1] ^ r_s3_grid[3];
        top_x  = '0;
        top_y  = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (diff_x[i]) top_x = LW'(i);
            if (diff_y[i]) top_y = LW'(i);
        end
        lvl_x = LW'(LEVEL_COUNT - 1) - top_x;
        lvl_y = LW'(LEVEL_COUNT - 1) - top_y;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_lvl <= (lvl_x < lvl_y) ? lvl_x : lvl_y;
            r_s4_gx  <= r_s3_grid[0];
            r_s4_gy  <= r_s3_grid[1];
            r_s4_out <= r_s3_out;
        end
    end

    // Stage 5: cell coordinates and the flat node index.
    // The level offset (4^level - 1) / 3 is the pattern 0101... cut to 2*level bits.
    logic [LW:0]    shift_amt;
    logic [NW-1:0]  cell_x_w, cell_y_w, level_base, node_w;
    t_result        n_res;
    t_result        r_res;

    always_comb begin
        shift_amt  = (LW + 1)'(LEVEL_COUNT) - (LW + 1)'(r_s4_lvl);
        cell_x_w   = NW'(r_s4_gx) >> shift_amt;
        cell_y_w   = NW'(r_s4_gy) >> shift_amt;
        level_base = ALT_ONES & ((NW'(1) << {r_s4_lvl, 1'b0}) - NW'(1));
        node_w     = level_base + (cell_y_w << r_s4_lvl) + cell_x_w;
        if (r_s4_out) begin
            n_res = '0;
            n_res.outside_area = 1'b1;
        end else begin
            n_res.outside_area = 1'b0;
            n_res.tree_level   = LEVEL_W'(r_s4_lvl);
            n_res.cell_x       = cell_x_w[CELL_W-1:0];
            n_res.cell_y       = cell_y_w[CELL_W-1:0];
            n_res.node_index   = node_w[NODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) r_res <= n_res;
    end

    assign o_res.valid = r_v5;
    assign o_res.data  = r_res;

    // Checks
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.outside_area |->
            o_res.data.tree_level == '0 && o_res.data.cell_x == '0
            && o_res.data.cell_y == '0 && o_res.data.node_index == '0)
        else $error("outside box gave a non-root node");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> o_res.valid && !o_res.ready)
        else $error("input stalled while the result side was free");

    a_cell_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.outside_area && LEVEL_COUNT <= 8 |->
            ((o_res.data.cell_x >> o_res.data.tree_level) == '0)
            && ((o_res.data.cell_y >> o_res.data.tree_level) == '0))
        else $error("cell lies beyond the width of its level");

    a_full_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && o_res.ready |=> r_v5)
        else $error("a finished word was lost on its way to the output");

endmodule

### dv/qtls_node_checker.sv
// Checker for the quad-tree level and cell selector: watches the box, result and
// configuration channels, predicts each node word and compares it field by field.
// Depends on qtls_pkg for the payload types and register indexes.
module qtls_node_checker #(
    parameter int LEVELS    = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_box_valid,
    input  logic              i_box_ready,
    input  qtls_pkg::t_box    i_box,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  qtls_pkg::t_result i_res,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  qtls_pkg::t_cfg    i_cfg,
    output int                o_pending,
    output int                o_fail_count
);
    import qtls_pkg::*;

    localparam int GRID_MAX = (1 << LEVELS) - 1;

    logic [REG_W-1:0] half_extent_q;
    logic [REG_W-1:0] grid_scale_q;
    t_result          expected_nodes[$];
    int               fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    // A minimum corner is floored and a maximum ceiled; both saturate at the grid edge.
    function automatic int corner_to_grid(input logic signed [CORNER_W-1:0] corner,
                                          input logic round_up);
        longint     shifted;
        logic [63:0] prod;
        logic [63:0] whole;
        shifted = longint'(corner) + longint'({1'b0, half_extent_q});
        if (shifted <= 0)
            return 0;
        prod  = 64'(shifted) * {33'd0, grid_scale_q};
        whole = prod >> (2 * FRAC_BITS);
        if (round_up && ((prod & ((64'd1 << (2 * FRAC_BITS)) - 64'd1)) != 64'd0))
            whole++;
        return (whole > 64'(GRID_MAX)) ? GRID_MAX : int'(whole);
    endfunction

    function automatic int axis_depth(input int lo, input int hi);
        int diff;
        diff = lo ^ hi;
        if (diff == 0)
            return LEVELS - 1;
        for (int b = LEVELS - 1; b >= 0; b--) begin
            if (diff[b])
                return LEVELS - 1 - b;
        end
        return 0;
    endfunction

    function automatic t_result predict_node(input t_box b);
        t_result r;
        longint  lim;
        int      gx0, gy0, gx1, gy1, lvl, cx, cy;
        longint  offset;
        r   = '0;
        lim = longint'({1'b0, half_extent_q});
        if (longint'($signed(b.box_min_x)) < -lim || longint'($signed(b.box_max_x)) > lim ||
            longint'($signed(b.box_min_y)) < -lim || longint'($signed(b.box_max_y)) > lim) begin
            r.outside_area = 1'b1;
            return r;
        end
        gx0 = corner_to_grid(b.box_min_x, 1'b0);
        gy0 = corner_to_grid(b.box_min_y, 1'b0);
        gx1 = corner_to_grid(b.box_max_x, 1'b1);
        gy1 = corner_to_grid(b.box_max_y, 1'b1);
        lvl = axis_depth(gx0, gx1);
        if (axis_depth(gy0, gy1) < lvl)
            lvl = axis_depth(gy0, gy1);
        cx = gx0 >> (LEVELS - lvl);
        cy = gy0 >> (LEVELS - lvl);
        offset = ((longint'(1) << (2 * lvl)) - 1) / 3;
        r.tree_level = LEVEL_W'(lvl);
        r.cell_x     = CELL_W'(cx);
        r.cell_y     = CELL_W'(cy);
        r.node_index = NODE_W'(offset + (longint'(cy) << lvl) + longint'(cx));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            half_extent_q = HALF_EXTENT_RESET;
            grid_scale_q  = GRID_SCALE_RESET;
            expected_nodes.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_index'(i_cfg.reg_index))
                    REG_HALF_EXTENT: half_extent_q = i_cfg.wr_data[REG_W-1:0];
                    REG_GRID_SCALE:  grid_scale_q  = i_cfg.wr_data[REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_box_valid && i_box_ready)
                expected_nodes.push_back(predict_node(i_box));
            if (i_res_valid && i_res_ready) begin
                if (expected_nodes.size() == 0) begin
                    report_mismatch("result word arrived with no box outstanding");
                end else begin
                    want = expected_nodes.pop_front();
                    if (i_res.outside_area !== want.outside_area)
                        report_mismatch($sformatf("outside_area got %0b expected %0b",
                                                  i_res.outside_area, want.outside_area));
                    if (i_res.tree_level !== want.tree_level)
                        report_mismatch($sformatf("tree_level got %0d expected %0d",
                                                  i_res.tree_level, want.tree_level));
                    if (i_res.cell_x !== want.cell_x)
                        report_mismatch($sformatf("cell_x got %0d expected %0d",
                                                  i_res.cell_x, want.cell_x));
                    if (i_res.cell_y !== want.cell_y)
                        report_mismatch($sformatf("cell_y got %0d expected %0d",
                                                  i_res.cell_y, want.cell_y));
                    if (i_res.node_index !== want.node_index)
                        report_mismatch($sformatf("node_index got %0d expected %0d",
                                                  i_res.node_index, want.node_index));
                end
            end
            o_pending <= expected_nodes.size();
        end
    end

endmodule

### dv/tb_quadtree_level_and_cell_select_unit.sv
// Testbench top for the quad-tree level and cell selector: drives boxes and register
// writes, stalls the result side, and gives the verdict from qtls_node_checker.
// Depends on qtls_pkg, the channel interfaces and the block itself.
module tb_quadtree_level_and_cell_select_unit;
    import qtls_pkg::*;

    localparam int BOXES_PER_PHASE = 98;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet;
    logic hold_req;
    logic hold_seen;
    int   pending_nodes;
    int   fail_count;
    logic [REG_W-1:0] area_half;

    qtls_box_if box_ch ();
    qtls_res_if res_ch ();
    qtls_cfg_if cfg_ch ();

    always #5 i_clk = ~i_clk;

    quadtree_level_and_cell_select_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    qtls_node_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_box_valid  (box_ch.valid),
        .i_box_ready  (box_ch.ready),
        .i_box        (box_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res        (res_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg        (cfg_ch.data),
        .o_pending    (pending_nodes),
        .o_fail_count (fail_count)
    );

    function automatic t_box make_box(input longint mnx, input longint mny,
                                      input longint mxx, input longint mxy);
        t_box b;
        b.box_min_x = CORNER_W'(mnx);
        b.box_min_y = CORNER_W'(mny);
        b.box_max_x = CORNER_W'(mxx);
        b.box_max_y = CORNER_W'(mxy);
        return b;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Mostly well-formed boxes of widely spread sizes inside the area, with some
    // inverted boxes, boxes poking out on one side, and plain noise.
    function automatic t_box random_box(input logic [REG_W-1:0] he);
        longint lim, span, size, tmp;
        longint lo[2];
        longint hi[2];
        int     mode;
        int     a;
        mode = $urandom_range(99);
        if (mode < 12)
            return t_box'({$urandom, $urandom, $urandom, $urandom});
        lim  = longint'({1'b0, he});
        span = 2 * lim;
        for (int k = 0; k < 2; k++) begin
            lo[k] = -lim + longint'($urandom_range(32'(span), 0));
            size  = longint'($urandom_range(32'(span), 0)) >> $urandom_range(32, 0);
            hi[k] = lo[k] + size;
            if (hi[k] > lim)
                hi[k] = lim;
            case ($urandom_range(9))
                0: lo[k] = -lim;
                1: hi[k] = lim;
                default: ;
            endcase
        end
        a = $urandom_range(1);
        if (mode < 18) begin
            tmp   = lo[a];
            lo[a] = hi[a];
            hi[a] = tmp;
        end else if (mode < 24) begin
            if ($urandom_range(1))
                lo[a] = -lim - 1 - longint'($urandom_range(255));
            else
                hi[a] = lim + 1 + longint'($urandom_range(255));
        end
        return make_box(sat32(lo[0]), sat32(lo[1]), sat32(hi[0]), sat32(hi[1]));
    endfunction

    // Offers one box and returns at the edge where it is taken; valid stays high
    // unless the next call idles first or the drain lowers it.
    task automatic push_box(input t_box b);
        if (!quiet && $urandom_range(99) < 16) begin
            box_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        box_ch.valid <= 1'b1;
        box_ch.data  <= b;
        @(posedge i_clk);
        while (!box_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [REG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t_cfg'{reg_index: idx, wr_data: {1'($urandom_range(1)), val}};
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [REG_W-1:0] he, input logic [REG_W-1:0] gs);
        write_reg(REG_HALF_EXTENT, he);
        write_reg(REG_GRID_SCALE, gs);
        cfg_ch.valid <= 1'b0;
        area_half = he;
    endtask

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++)
            push_box(random_box(area_half));
    endtask

    task automatic drain_nodes();
        box_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_nodes != 0);
    endtask

    // Result side: short random stalls, or one long hold-off whenever the request
    // toggles, so that the pipeline fills and pushes back on the box channel.
    initial begin
        res_ch.ready <= 1'b0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(99) < 14) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        longint h;
        logic [REG_W-1:0] he_pick;
        box_ch.valid <= 1'b0;
        box_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        quiet        <= 1'b0;
        hold_req     <= 1'b0;
        area_half     = HALF_EXTENT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset register values.
        h = longint'({1'b0, HALF_EXTENT_RESET});
        push_box(make_box(0, 0, 0, 0));
        push_box(make_box(-h, -h, h, h));
        push_box(make_box(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                          64'sd2147483647));
        push_box(make_box(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          64'sd2147483647));
        push_box(make_box(-64'sd2147483648, 0, 0, 0));
        push_box(make_box(-h - 1, 0, 0, 0));
        push_box(make_box(0, -h - 1, 0, 0));
        push_box(make_box(0, 0, h + 1, 0));
        push_box(make_box(0, 0, 0, h + 1));
        push_box(make_box(-h, -h, -h, -h));
        push_box(make_box(h, h, h, h));
        push_box(make_box(h / 2, h / 2, -h / 2, -h / 2));
        // Maxima below the area are not checked against the lower bound.
        push_box(make_box(-h, -h, -h - 1, -h - 5));
        push_box(make_box(-1, -1, 1, 1));
        push_box(make_box(h / 4, h / 4, h / 4 + 100, h / 4 + 100));
        push_box(make_box(-h / 2, h / 4, -h / 2 + 10, h / 2));
        push_box(make_box(3, 5, 7, 9));
        push_box(make_box(h - 1, -h, h, -h + 1));
        push_random(BOXES_PER_PHASE);
        drain_nodes();

        for (int phase = 1; phase < 8; phase++) begin
            he_pick = REG_W'($urandom_range(32'h7FFF_FFFF, 32'd1024));
            case (phase)
                1: program_regs(31'd65536, 31'd8355840);
                2: program_regs(31'd1048576, 31'd522240);
                3: program_regs(31'h7FFF_FFFF, 31'd255);
                4: program_regs(31'd1, 31'h7FFF_FFFF);
                5: program_regs(31'd0, REG_W'($urandom));
                6: program_regs(REG_W'($urandom), 31'd0);
                default: program_regs(he_pick,
                                      REG_W'((64'd255 << 31) / longint'({1'b0, he_pick})));
            endcase
            quiet <= (phase == 1);
            if (phase == 2 || phase == 7)
                hold_req <= ~hold_req;
            push_random(BOXES_PER_PHASE);
            drain_nodes();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/qtls_pkg.sv
src/qtls_if.sv
src/quadtree_level_and_cell_select_unit.sv
dv/qtls_node_checker.sv
dv/tb_quadtree_level_and_cell_select_unit.sv
